### sv/tmps_pkg.sv
// Shared types and constants for the triangle maximum path sum unit.
package tmps_pkg;

   localparam int ENTRY_W      = 16;
   localparam int SUM_W        = 24;
   localparam int CFG_W        = 8;
   localparam int DEF_MAX_ROWS = 128;
   localparam int QUEUE_DEPTH  = 4;

   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

   // What the front end learned about one entry
   typedef struct packed {
      logic has_left;     // column above-left exists
      logic has_right;    // column directly above exists
      logic last_row;     // entry belongs to the bottom row
      logic final_entry;  // last entry of the triangle
   } entry_flags_type;

   localparam int FLAGS_W = $bits(entry_flags_type);

endpackage

### sv/tmps_front.sv
// Front end: row/column tracking and classification of incoming entries.
module tmps_front import tmps_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   localparam int IDX_W = $clog2(MAX_ROWS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 push,
   output logic [IDX_W-1:0]     col,
   output entry_flags_type      flags
);

   logic [CFG_W-1:0] row_count_ff, row_count_in;
   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] col_ff, col_in;
   logic [IDX_W-1:0] last_idx;
   int               eff_rows;

   always_comb begin
      if (row_count_ff == '0) begin
         eff_rows = 1;
      end else if (int'(row_count_ff) > MAX_ROWS) begin
         eff_rows = MAX_ROWS;
      end else begin
         eff_rows = int'(row_count_ff);
      end
      last_idx = IDX_W'(eff_rows - 1);
   end

   always_comb begin
      flags.has_left    = (col_ff != '0);
      flags.has_right   = (col_ff != row_ff);
      flags.last_row    = (row_ff == last_idx);
      flags.final_entry = flags.last_row && (col_ff == row_ff);
      col               = col_ff;

      row_count_in = row_count_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      if (csr_we) begin
         row_count_in = csr_wdata;
         row_in       = '0;
         col_in       = '0;
      end else if (push) begin
         if (col_ff != row_ff) begin
            col_in = col_ff + 1'b1;
         end else if (!flags.last_row) begin
            row_in = row_ff + 1'b1;
            col_in = '0;
         end else begin
            row_in = '0;
            col_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= CFG_W'(1);
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         row_count_ff <= row_count_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

endmodule

### sv/tmps_queue.sv
// Small FIFO between the front end and the back end.
module tmps_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/tmps_back.sv
// Back end: row buffer read-modify-write, running bottom-row max, result register.
module tmps_back import tmps_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   localparam int IDX_W = $clog2(MAX_ROWS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic                       q_not_empty,
   input  logic signed [ENTRY_W-1:0]  q_value,
   input  logic [IDX_W-1:0]           q_col,
   input  entry_flags_type            q_flags,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic signed [SUM_W-1:0]    rsp_tdata
);

   logic signed [SUM_W-1:0] row_sums [MAX_ROWS];

   logic                      b_valid_ff, b_valid_in;
   logic signed [ENTRY_W-1:0] b_value_ff;
   logic [IDX_W-1:0]          b_col_ff;
   entry_flags_type           b_flags_ff;
   logic                      fwd_ff, fwd_in;
   logic signed [SUM_W-1:0]   rd_ff;
   logic signed [SUM_W-1:0]   last_sum_ff;
   logic signed [SUM_W-1:0]   left_ff;
   logic signed [SUM_W-1:0]   bottom_ff, bottom_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0]   rsp_data_ff;

   logic                      adv;
   logic                      wr_en;
   logic signed [SUM_W-1:0]   old_here;
   logic signed [SUM_W-1:0]   best;
   logic signed [SUM_W:0]     wide_sum;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   new_max;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign q_pop      = adv && q_not_empty;
   assign wr_en      = adv && b_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      // previous item wrote this column while our read was in flight
      old_here = fwd_ff ? last_sum_ff : rd_ff;

      if (b_flags_ff.has_left && b_flags_ff.has_right) begin
         best = (old_here > left_ff) ? old_here : left_ff;
      end else if (b_flags_ff.has_left) begin
         best = left_ff;
      end else if (b_flags_ff.has_right) begin
         best = old_here;
      end else begin
         best = '0;
      end

      wide_sum = (SUM_W+1)'(b_value_ff) + (SUM_W+1)'(best);
      if (wide_sum > (SUM_W+1)'(SUM_MAX)) begin
         sum = SUM_MAX;
      end else if (wide_sum < (SUM_W+1)'(SUM_MIN)) begin
         sum = SUM_MIN;
      end else begin
         sum = wide_sum[SUM_W-1:0];
      end

      new_max = (sum > bottom_ff) ? sum : bottom_ff;

      b_valid_in   = adv ? q_not_empty : b_valid_ff;
      fwd_in       = fwd_ff;
      bottom_in    = bottom_ff;
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         fwd_in       = wr_en && (b_col_ff == q_col);
         rsp_valid_in = b_valid_ff && b_flags_ff.final_entry;
      end
      if (csr_we) begin
         bottom_in = SUM_MIN;
      end else if (wr_en && b_flags_ff.final_entry) begin
         bottom_in = SUM_MIN;
      end else if (wr_en && b_flags_ff.last_row) begin
         bottom_in = new_max;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         fwd_ff       <= 1'b0;
         bottom_ff    <= SUM_MIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         fwd_ff       <= fwd_in;
         bottom_ff    <= bottom_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_value_ff <= q_value;
         b_col_ff   <= q_col;
         b_flags_ff <= q_flags;
         rd_ff      <= row_sums[q_col];
      end
      if (wr_en) begin
         row_sums[b_col_ff] <= sum;
         last_sum_ff        <= sum;
         left_ff            <= old_here;
      end
      if (wr_en && b_flags_ff.final_entry) begin
         rsp_data_ff <= new_max;
      end
   end

   a_fwd_needs_prior: assert property (@(posedge clock) disable iff (reset)
      fwd_ff && b_valid_ff |-> $past(b_valid_ff))
      else $error("forward flag set without a preceding write");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(b_valid_ff) && $stable(b_col_ff))
      else $error("back stage moved while result stalled");

   a_final_emits: assert property (@(posedge clock) disable iff (reset)
      wr_en && b_flags_ff.final_entry |=> rsp_valid_ff)
      else $error("final entry did not produce a result");

   a_left_col0: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !b_flags_ff.has_left |-> b_col_ff == '0)
      else $error("entry without left parent not in column zero");

endmodule

### sv/triangle_max_path_sum_unit.sv
// Top level of the triangle maximum path sum unit.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata[15:0] entry_value
//  rsp     | out | rsp_tvalid/tready    | tdata[23:0] best_sum
//  csr     | in  | csr_we               | csr_wdata[7:0] row_count
//
// One entry per cycle while the result is not stalled; the final entry's value passes the
// queue slot, then the row-buffer read stage, then its sum goes into the result register
// that drives rsp_tvalid; classification is combinational.
// The row buffer does one read and one write per cycle; a same-column hazard
// between neighboring entries is covered by forwarding the last written sum.
// Reset is synchronous; row_count returns to 1. No clearing pass is needed.
// A stalled result holds the back end; the 4-entry queue keeps req ready until full.
module triangle_max_path_sum_unit import tmps_pkg::*; #(
   parameter int MAX_ROWS = DEF_MAX_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ENTRY_W-1:0]    req_tdata,   // [15:0] entry_value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SUM_W-1:0]      rsp_tdata,   // [23:0] best_sum
   input  logic                  csr_we,
   input  logic [CFG_W-1:0]      csr_wdata    // [7:0] row_count
);

   localparam int IDX_W = $clog2(MAX_ROWS);
   localparam int Q_W   = FLAGS_W + IDX_W + ENTRY_W;

   logic              push;
   logic              q_full;
   logic              q_not_empty;
   logic              q_pop;
   logic [IDX_W-1:0]  f_col;
   entry_flags_type   f_flags;
   logic [Q_W-1:0]    q_in;
   logic [Q_W-1:0]    q_out;
   entry_flags_type   q_flags;
   logic [IDX_W-1:0]  q_col;
   logic signed [ENTRY_W-1:0] q_value;
   logic signed [SUM_W-1:0]   rsp_sum;

   assign req_tready = !q_full;
   assign push       = req_tvalid && req_tready;
   assign q_in       = {f_flags, f_col, req_tdata};
   assign q_value    = q_out[ENTRY_W-1:0];
   assign q_col      = q_out[ENTRY_W +: IDX_W];
   assign q_flags    = q_out[ENTRY_W+IDX_W +: FLAGS_W];
   assign rsp_tdata  = rsp_sum;

   tmps_front #(.MAX_ROWS(MAX_ROWS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .push      (push),
      .col       (f_col),
      .flags     (f_flags)
   );

   tmps_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_out)
   );

   tmps_back #(.MAX_ROWS(MAX_ROWS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .q_not_empty (q_not_empty),
      .q_value     (q_value),
      .q_col       (q_col),
      .q_flags     (q_flags),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_sum)
   );

endmodule

### verif/tb_top.sv
// Self-checking testbench for the triangle maximum path sum unit.
module tb_top;
   import tmps_pkg::*;

   localparam int SETTLE_CYCLES  = 12;    // pipeline drain before a row_count write
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int ITEMS_PER_MODE = 520;
   localparam int PARTIAL_LIMIT  = 40;    // longest abandoned partial triangle

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ENTRY_W-1:0]  req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [SUM_W-1:0]    rsp_tdata;
   logic                csr_we;
   logic [CFG_W-1:0]    csr_wdata;

   triangle_max_path_sum_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // pending entries, expected best sums, flow bookkeeping
   logic [ENTRY_W-1:0]       entry_q[$];
   logic signed [SUM_W-1:0]  best_sum_q[$];
   int unsigned              entries_in_flight = 0;
   int unsigned              entries_queued = 0;
   int unsigned              error_count = 0;
   int unsigned              stall_cycles = 0;
   int unsigned              send_idle_pct = 14;
   int unsigned              recv_idle_pct = 59;
   logic                     req_taken = 1'b0;

   // predictor state
   logic signed [SUM_W-1:0]  path_sums [DEF_MAX_ROWS];
   int unsigned              row_pos;
   int unsigned              col_pos;
   logic signed [SUM_W-1:0]  left_sum;
   logic signed [SUM_W-1:0]  bottom_max;
   logic [CFG_W-1:0]         row_count_reg;

   function automatic void restart_triangle();
      row_pos    = 0;
      col_pos    = 0;
      left_sum   = '0;
      bottom_max = SUM_MIN;
   endfunction

   // Folds one entry into the row of best sums; returns 1 when the triangle completes.
   function automatic bit triangle_step(input logic signed [ENTRY_W-1:0] value,
                                        output logic signed [SUM_W-1:0] best);
      int unsigned             rows;
      int unsigned             r;
      int unsigned             c;
      int                      parent;
      int                      sum;
      bit                      have_parent;
      logic signed [SUM_W-1:0] above;
      rows = (row_count_reg == 0) ? 1 :
             (row_count_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : row_count_reg;
      r = (row_pos >= rows) ? rows - 1 : row_pos;
      c = (col_pos > r) ? r : col_pos;
      above = path_sums[c];
      parent = 0;
      have_parent = 1'b0;
      if (c > 0) begin
         parent = left_sum;
         have_parent = 1'b1;
      end
      if (c < r) begin
         if (!have_parent || above > parent) parent = above;
         have_parent = 1'b1;
      end
      sum = value + parent;
      if (sum > SUM_MAX) sum = SUM_MAX;
      else if (sum < SUM_MIN) sum = SUM_MIN;
      left_sum = above;
      path_sums[c] = SUM_W'(sum);
      if (r + 1 >= rows && sum > bottom_max) bottom_max = SUM_W'(sum);
      best = bottom_max;
      if (c < r) begin
         col_pos = c + 1;
         row_pos = r;
         return 1'b0;
      end
      if (r + 1 < rows) begin
         row_pos  = r + 1;
         col_pos  = 0;
         left_sum = '0;
         return 1'b0;
      end
      restart_triangle();
      return 1'b1;
   endfunction

   function automatic logic [ENTRY_W-1:0] rand_entry();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 15));
         3: return 16'hFFFF - 16'($urandom_range(0, 15));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic queue_entry(input logic [ENTRY_W-1:0] value);
      entry_q.push_back(value);
      entries_in_flight++;
      entries_queued++;
   endtask

   // wait until every entry is taken and every best sum has come back
   task automatic settle();
      do @(negedge clock);
      while (entries_in_flight != 0 || best_sum_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_rows(input logic [CFG_W-1:0] rows);
      settle();
      csr_wdata <= rows;
      csr_we    <= 1'b1;
      row_count_reg = rows;
      restart_triangle();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // full triangles of random entries, optionally followed by an abandoned partial one
   task automatic run_triangles(input logic [CFG_W-1:0] rows_cfg, input int unsigned count,
                                input bit abandon);
      int unsigned rows;
      int unsigned per_triangle;
      int unsigned total;
      set_rows(rows_cfg);
      rows = (rows_cfg == 0) ? 1 : (rows_cfg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows_cfg;
      per_triangle = rows * (rows + 1) / 2;
      total = count * per_triangle;
      if (abandon && rows > 1) begin
         total += $urandom_range(1, (per_triangle > PARTIAL_LIMIT) ? PARTIAL_LIMIT :
                                    per_triangle - 1);
      end
      repeat (total) queue_entry(rand_entry());
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // entry source
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (entry_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tdata  <= entry_q.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result sink backpressure
   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // check results, then predict from accepted entries
   always @(posedge clock) begin : monitor_p
      logic signed [SUM_W-1:0] best;
      logic signed [SUM_W-1:0] want;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (best_sum_q.size() == 0) begin
            $error("best_sum: expected none, got %0d", $signed(rsp_tdata));
            error_count++;
         end else begin
            want = best_sum_q.pop_front();
            if (rsp_tdata !== want) begin
               $error("best_sum: expected %0d, got %0d", want, $signed(rsp_tdata));
               error_count++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         entries_in_flight--;
         if (triangle_step(req_tdata, best)) best_sum_q.push_back(best);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus_p
      int unsigned mode;
      int unsigned mode_start;
      int unsigned pick;
      logic [CFG_W-1:0] rows_cfg;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      foreach (path_sums[i]) path_sums[i] = '0;
      row_count_reg = 8'd1;
      restart_triangle();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // one-row triangles under the reset row count
      queue_entry(16'h7FFF);
      queue_entry(16'h8000);
      queue_entry(16'h0000);
      queue_entry(16'hFFFF);
      // zero rows behaves as one
      set_rows(8'd0);
      queue_entry(16'h0001);
      queue_entry(16'h8000);
      // row ends have a single parent
      set_rows(8'd2);
      queue_entry(16'h8000);
      queue_entry(16'h7FFF);
      queue_entry(16'h8000);
      queue_entry(16'h7FFF);
      queue_entry(16'h8000);
      queue_entry(16'h7FFF);
      // all-max triangle, then a triangle cut short by a row_count write
      set_rows(8'd3);
      repeat (6) queue_entry(16'h7FFF);
      queue_entry(16'h1234);
      queue_entry(16'h8000);
      queue_entry(16'h7FFF);

      for (mode = 0; mode < 3; mode++) begin
         settle();
         send_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 59 : 0;
         recv_idle_pct = (mode == 0) ? 59 : (mode == 1) ? 14 : 0;
         mode_start = entries_queued;
         while (entries_queued - mode_start < ITEMS_PER_MODE) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) rows_cfg = 8'd0;
            else if (pick == 1) rows_cfg = 8'd1;
            else if (pick == 2) rows_cfg = 8'($urandom_range(13, 24));
            else rows_cfg = 8'($urandom_range(2, 12));
            run_triangles(rows_cfg, $urandom_range(1, 4), $urandom_range(0, 3) == 0);
         end
         // largest row count and the largest csr value (above the limit), each cut short
         if (mode == 0) run_triangles(8'd128, 0, 1'b1);
         if (mode == 2) run_triangles(8'd255, 0, 1'b1);
      end

      settle();
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
